FILE: rtl/core/gfl_pkg.sv
// Shared types, constants and helpers for the grid field trilinear lookup.
// Used by all rtl/core modules but gfl_grid_ram; depends on nothing.
package gfl_pkg;

	// Grid dimensions
	localparam int GRID_X   = 16;
	localparam int GRID_Y   = 16;
	localparam int GRID_Z   = 16;
	localparam int GRID_MAX = (GRID_X > GRID_Y) ? ((GRID_X > GRID_Z) ? GRID_X : GRID_Z)
	                                            : ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
	localparam int CELL_W   = $clog2(GRID_MAX);

	// Sample store
	localparam int IDX_W    = 12;
	localparam int DEPTH    = 1 << IDX_W;
	localparam int SAMP_W   = 24;
	localparam int ENTRY_W  = 3 * SAMP_W;

	// Fixed point
	localparam int COORD_W  = 32;
	localparam int FRAC_W   = 16;
	localparam int WT_W     = FRAC_W + 1;
	localparam int APER_W   = 63;
	localparam int CFG_W    = 63;
	localparam int CFG_A_W  = 3;

	// Register indexes
	localparam logic [CFG_A_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_A_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_A_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_A_W-1:0] REG_INV_X    = 3'd3;
	localparam logic [CFG_A_W-1:0] REG_INV_Y    = 3'd4;
	localparam logic [CFG_A_W-1:0] REG_INV_Z    = 3'd5;
	localparam logic [CFG_A_W-1:0] REG_APER     = 3'd6;

	// Actions
	localparam logic ACT_QUERY = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	// Located position on one axis: lower cell and the two lerp weights
	typedef struct packed {
		logic              in_grid;
		logic [CELL_W-1:0] lo;
		logic [WT_W-1:0]   w0;
		logic [WT_W-1:0]   w1;
	} axis_pos_t;

	// Flat index, x fastest, wrapped to the store depth
	function automatic logic [IDX_W-1:0] flat_index(input logic [CELL_W:0] i,
		input logic [CELL_W:0] j, input logic [CELL_W:0] k);
		logic [31:0] v;
		v = 32'(i) + 32'(GRID_X) * (32'(j) + 32'(GRID_Y) * 32'(k));
		return v[IDX_W-1:0];
	endfunction

endpackage

FILE: rtl/core/grid_field_trilinear_lookup_unit.sv
// Top level: config registers, sequencer, sample RAM, locators, three lanes.
// Depends on gfl_pkg, gfl_grid_ram, gfl_locate, gfl_lane.
// Write transaction: busy stays low, one write per cycle while idle. Query inside the
// grid: the locate pipeline, decide, 8 corner reads through the single RAM port, the
// registered RAM read, 6 lerp stages, then done; outside, done follows decide. One
// transaction at a time. Reset clears control, result, origin and aperture registers
// and sets the inverses to 1.0; RAM contents are undefined.
// done pulses one cycle with the result; the receiver cannot stall.
module grid_field_trilinear_lookup_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	output logic                                done,
	input  logic                                cfg_we,
	input  logic [gfl_pkg::CFG_A_W-1:0]         cfg_addr,
	input  logic [gfl_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                action,
	input  logic signed [gfl_pkg::COORD_W-1:0]  coord_x,
	input  logic signed [gfl_pkg::COORD_W-1:0]  coord_y,
	input  logic signed [gfl_pkg::COORD_W-1:0]  coord_z,
	input  logic [gfl_pkg::IDX_W-1:0]           sample_index,
	input  logic signed [gfl_pkg::SAMP_W-1:0]   sample_bx,
	input  logic signed [gfl_pkg::SAMP_W-1:0]   sample_by,
	input  logic signed [gfl_pkg::SAMP_W-1:0]   sample_bz,
	output logic signed [gfl_pkg::SAMP_W-1:0]   field_x,
	output logic signed [gfl_pkg::SAMP_W-1:0]   field_y,
	output logic signed [gfl_pkg::SAMP_W-1:0]   field_z,
	output logic                                inside_res
);
	import gfl_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PREP   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_WAIT   = 3'd4;

	localparam int SQ_W = 2 * COORD_W;

	logic [2:0]             state_q;
	logic [2:0]             cnt_q;
	logic [COORD_W-1:0]     org_x_q, org_y_q, org_z_q;
	logic [COORD_W-1:0]     inv_x_q, inv_y_q, inv_z_q;
	logic [APER_W-1:0]      aper_q;
	logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
	logic [COORD_W-1:0]     abs_x, abs_y;
	logic [SQ_W-1:0]        sqx_s1, sqy_s1;
	logic                   ap_ok_s2;
	axis_pos_t              pos_x, pos_y, pos_z;
	logic                   accept;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_addr, rd_addr;
	logic [ENTRY_W-1:0]     ram_rdata;
	logic                   rvalid_q;
	logic [2:0]             rcorner_q;
	logic                   vx, vy, vz;
	logic signed [SAMP_W-1:0] rx, ry, rz;

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign ram_we   = accept && (action == ACT_WRITE);
	assign rd_addr  = flat_index({1'b0, pos_x.lo} + (CELL_W+1)'(cnt_q[0]),
	                             {1'b0, pos_y.lo} + (CELL_W+1)'(cnt_q[1]),
	                             {1'b0, pos_z.lo} + (CELL_W+1)'(cnt_q[2]));
	assign ram_addr = (state_q == ST_READ) ? rd_addr : sample_index;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0; org_y_q <= '0; org_z_q <= '0;
			inv_x_q <= COORD_W'(1) << FRAC_W;
			inv_y_q <= COORD_W'(1) << FRAC_W;
			inv_z_q <= COORD_W'(1) << FRAC_W;
			aper_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ORIGIN_X: org_x_q <= cfg_wdata[COORD_W-1:0];
				REG_ORIGIN_Y: org_y_q <= cfg_wdata[COORD_W-1:0];
				REG_ORIGIN_Z: org_z_q <= cfg_wdata[COORD_W-1:0];
				REG_INV_X:    inv_x_q <= cfg_wdata[COORD_W-1:0];
				REG_INV_Y:    inv_y_q <= cfg_wdata[COORD_W-1:0];
				REG_INV_Z:    inv_z_q <= cfg_wdata[COORD_W-1:0];
				REG_APER:     aper_q  <= cfg_wdata[APER_W-1:0];
				default: ;
			endcase
		end
	end

	// Query point latch
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q <= coord_x;
			cy_q <= coord_y;
			cz_q <= coord_z;
		end
	end

	// Magnitudes for the radial test; -2^31 maps to 2^31
	assign abs_x = cx_q[COORD_W-1] ? COORD_W'(-cx_q) : cx_q;
	assign abs_y = cy_q[COORD_W-1] ? COORD_W'(-cy_q) : cy_q;

	// Aperture check: full 64-bit squares, then sum and compare
	always_ff @(posedge clk) begin
		sqx_s1   <= abs_x * abs_x;
		sqy_s1   <= abs_y * abs_y;
		ap_ok_s2 <= (aper_q == '0) || ((sqx_s1 + sqy_s1) <= SQ_W'(aper_q));
	end

	gfl_locate u_loc_x (.clk, .coord(cx_q), .origin(org_x_q), .inv(inv_x_q),
		.last_cell(CELL_W'(GRID_X - 1)), .pos(pos_x));
	gfl_locate u_loc_y (.clk, .coord(cy_q), .origin(org_y_q), .inv(inv_y_q),
		.last_cell(CELL_W'(GRID_Y - 1)), .pos(pos_y));
	gfl_locate u_loc_z (.clk, .coord(cz_q), .origin(org_z_q), .inv(inv_z_q),
		.last_cell(CELL_W'(GRID_Z - 1)), .pos(pos_z));

	gfl_grid_ram #(.DEPTH(DEPTH), .WIDTH(ENTRY_W), .AW(IDX_W)) u_ram (
		.clk, .we(ram_we), .addr(ram_addr),
		.wdata({sample_bx, sample_by, sample_bz}), .rdata(ram_rdata));

	// Read data tag, aligned with the RAM output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q  <= 1'b0;
			rcorner_q <= '0;
		end else begin
			rvalid_q  <= (state_q == ST_READ);
			rcorner_q <= cnt_q;
		end
	end

	gfl_lane u_lane_x (.clk, .arst_n, .in_valid(rvalid_q), .in_corner(rcorner_q),
		.sample(ram_rdata[3*SAMP_W-1:2*SAMP_W]), .px(pos_x), .py(pos_y), .pz(pos_z),
		.res_valid(vx), .res(rx));
	gfl_lane u_lane_y (.clk, .arst_n, .in_valid(rvalid_q), .in_corner(rcorner_q),
		.sample(ram_rdata[2*SAMP_W-1:SAMP_W]), .px(pos_x), .py(pos_y), .pz(pos_z),
		.res_valid(vy), .res(ry));
	gfl_lane u_lane_z (.clk, .arst_n, .in_valid(rvalid_q), .in_corner(rcorner_q),
		.sample(ram_rdata[SAMP_W-1:0]), .px(pos_x), .py(pos_y), .pz(pos_z),
		.res_valid(vz), .res(rz));

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			done       <= 1'b0;
			inside_res <= 1'b0;
			field_x    <= '0;
			field_y    <= '0;
			field_z    <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && action == ACT_QUERY) state_q <= ST_PREP;
				end
				ST_PREP: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					cnt_q <= '0;
					if (pos_x.in_grid && pos_y.in_grid && pos_z.in_grid && ap_ok_s2) begin
						state_q <= ST_READ;
					end else begin
						state_q    <= ST_IDLE;
						done       <= 1'b1;
						inside_res <= 1'b0;
						field_x    <= '0;
						field_y    <= '0;
						field_z    <= '0;
					end
				end
				ST_READ: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (vx) begin
						state_q    <= ST_IDLE;
						done       <= 1'b1;
						inside_res <= 1'b1;
						field_x    <= rx;
						field_y    <= ry;
						field_z    <= rz;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks
	a_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_IDLE)
		else $error("RAM write outside idle");
	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		vx == vy && vy == vz)
		else $error("lane results out of step");
	a_lane_wait: assert property (@(posedge clk) disable iff (!arst_n)
		vx |-> state_q == ST_WAIT)
		else $error("lane result outside wait");
	a_out_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !inside_res |-> field_x == '0 && field_y == '0 && field_z == '0)
		else $error("outside result not zero");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_DECIDE || $past(state_q) == ST_WAIT)
		else $error("done from wrong state");
endmodule

FILE: rtl/core/gfl_grid_ram.sv
// Single-port synchronous RAM, registered read; rdata holds during a write.
// Generic; no package dependency.
module gfl_grid_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 72,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end
endmodule

FILE: rtl/core/gfl_locate.sv
// Axis locator: grid-unit position, range check, lower cell and weights.
// Four-stage pipeline, 32x16 partial products. Depends on gfl_pkg.
module gfl_locate (
	input  logic                            clk,
	input  logic [gfl_pkg::COORD_W-1:0]     coord,
	input  logic [gfl_pkg::COORD_W-1:0]     origin,
	input  logic [gfl_pkg::COORD_W-1:0]     inv,
	input  logic [gfl_pkg::CELL_W-1:0]      last_cell,
	output gfl_pkg::axis_pos_t              pos
);
	import gfl_pkg::*;

	localparam int U_W = COORD_W + FRAC_W + 1;

	logic [COORD_W:0]        diff;
	logic [COORD_W-1:0]      d_s1, d_s2;
	logic                    neg_s1, neg_s2, neg_s3;
	logic [COORD_W+FRAC_W-1:0] plo_s2;
	logic [U_W-1:0]          u_s3;
	logic [U_W-1:0]          top;

	assign diff = {coord[COORD_W-1], coord} - {origin[COORD_W-1], origin};
	assign top  = U_W'({last_cell, {FRAC_W{1'b0}}});

	// s1: offset from origin
	always_ff @(posedge clk) begin
		d_s1   <= diff[COORD_W-1:0];
		neg_s1 <= diff[COORD_W];
	end

	// s2: low-half product
	always_ff @(posedge clk) begin
		plo_s2 <= d_s1 * inv[FRAC_W-1:0];
		d_s2   <= d_s1;
		neg_s2 <= neg_s1;
	end

	// s3: high-half product plus carried low half
	always_ff @(posedge clk) begin
		u_s3   <= U_W'(d_s2 * inv[COORD_W-1:FRAC_W])
		          + U_W'(plo_s2[COORD_W+FRAC_W-1:FRAC_W]);
		neg_s3 <= neg_s2;
	end

	// s4: range check, upper edge uses the last cell with full weight
	always_ff @(posedge clk) begin
		pos.in_grid <= !neg_s3 && (u_s3 <= top);
		if (u_s3 == top) begin
			pos.lo <= last_cell - CELL_W'(1);
			pos.w0 <= '0;
			pos.w1 <= WT_W'(1) << FRAC_W;
		end else begin
			pos.lo <= u_s3[FRAC_W +: CELL_W];
			pos.w0 <= (WT_W'(1) << FRAC_W) - WT_W'(u_s3[FRAC_W-1:0]);
			pos.w1 <= WT_W'(u_s3[FRAC_W-1:0]);
		end
	end
endmodule

FILE: rtl/core/gfl_lane.sv
// One field component: six-stage lerp pipeline over the eight corners.
// Corners arrive x fastest, then y, then z. Depends on gfl_pkg.
module gfl_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [2:0]                        in_corner,
	input  logic signed [gfl_pkg::SAMP_W-1:0] sample,
	input  gfl_pkg::axis_pos_t                px,
	input  gfl_pkg::axis_pos_t                py,
	input  gfl_pkg::axis_pos_t                pz,
	output logic                              res_valid,
	output logic signed [gfl_pkg::SAMP_W-1:0] res
);
	import gfl_pkg::*;

	localparam int C_W = SAMP_W + WT_W + 1;
	localparam int Y_W = C_W + WT_W + 1;
	localparam int E_W = Y_W - FRAC_W;
	localparam int Z_W = E_W + WT_W + 1;

	logic                  v1, v2, v3, v4, v5;
	logic [2:0]            n1;
	logic [1:0]            n2, n3;
	logic                  n4, n5;
	logic signed [C_W-1:0] p1, cacc, c2;
	logic signed [Y_W-1:0] p3, eacc, esum;
	logic signed [E_W-1:0] e4;
	logic signed [Z_W-1:0] p5, zacc, zsum;

	assign esum = eacc + p3 + (Y_W'(1) <<< (FRAC_W - 1));
	assign zsum = zacc + p5 + (Z_W'(1) <<< (2 * FRAC_W - 1));

	// Control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			v1 <= in_valid;
			v2 <= v1 && n1[0];
			v3 <= v2;
			v4 <= v3 && n3[0];
			v5 <= v4;
			res_valid <= v5 && n5;
		end
	end

	// Data pipeline
	always_ff @(posedge clk) begin
		// s1: x weight
		p1 <= C_W'(sample) * $signed({1'b0, in_corner[0] ? px.w1 : px.w0});
		n1 <= in_corner;
		// s2: x lerp
		if (v1 && !n1[0]) cacc <= p1;
		c2 <= cacc + p1;
		n2 <= n1[2:1];
		// s3: y weight
		p3 <= Y_W'(c2) * $signed({1'b0, n2[0] ? py.w1 : py.w0});
		n3 <= n2;
		// s4: y lerp, round to scale 2^16
		if (v3 && !n3[0]) eacc <= p3;
		e4 <= E_W'(esum >>> FRAC_W);
		n4 <= n3[1];
		// s5: z weight
		p5 <= Z_W'(e4) * $signed({1'b0, n4 ? pz.w1 : pz.w0});
		n5 <= n4;
		// s6: z lerp, round back to the sample scale, Q24.0
		if (v5 && !n5) zacc <= p5;
		res <= SAMP_W'(zsum >>> (2 * FRAC_W));
	end
endmodule

FILE: dv/grid_field_trilinear_lookup_unit_tb.sv
// Testbench for grid_field_trilinear_lookup_unit: writes grid entries before queries read them,
// runs directed and random queries under several register settings and checks every result.
// Depends on gfl_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module grid_field_trilinear_lookup_unit_tb;
	import gfl_pkg::*;

	localparam logic [CFG_A_W-1:0] REG_UNUSED = 3'd7;
	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		logic              act;
		logic [31:0]       cx, cy, cz;
		logic [IDX_W-1:0]  idx;
		logic [SAMP_W-1:0] bx, by, bz;
		bit                typed;
	} item_t;

	typedef struct {
		logic [SAMP_W-1:0] fx, fy, fz;
		logic              ins;
	} field_res_t;

	typedef struct {
		int          ox, oy, oz;
		int unsigned ix, iy, iz;
		longint unsigned aper;
		int unsigned span;
	} setting_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic cfg_we = 1'b0;
	logic [CFG_A_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic action = ACT_QUERY;
	logic signed [COORD_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
	logic [IDX_W-1:0] sample_index = '0;
	logic signed [SAMP_W-1:0] sample_bx = '0, sample_by = '0, sample_bz = '0;
	logic signed [SAMP_W-1:0] field_x, field_y, field_z;
	logic inside_res;

	grid_field_trilinear_lookup_unit i_dut (.*);

	always #1 clk = ~clk;

	// Mirror of the configuration and the sample store
	longint          org_m[3];
	longint unsigned inv_m[3];
	longint unsigned aper_m;
	int              store_m[3][DEPTH];
	bit              written_m[DEPTH];
	field_res_t      pending_fields[$];
	int errors = 0, n_query = 0, n_write = 0, n_inside = 0, n_cfg = 0;
	bit quiet = 0;
	int idle_cnt = 0;

	// Grid position on one axis; returns 0 when outside
	function automatic bit locate_axis(input logic [31:0] c, input longint org,
		input longint unsigned inv, input int n, output int lo, output longint t);
		longint diff;
		longint unsigned d, u, top;
		diff = longint'(signed'(c)) - org;
		lo = 0;
		t = 0;
		if (diff < 0) return 0;
		d = diff;
		u = d * (inv >> 16) + ((d * (inv & 64'hFFFF)) >> 16);
		top = longint'(n - 1) << 16;
		if (u > top) return 0;
		if (u == top) begin
			lo = n - 2;
			t = 65536;
		end else begin
			lo = int'(u >> 16);
			t = longint'(u & 64'hFFFF);
		end
		return 1;
	endfunction

	function automatic int cell_addr(input int i, input int j, input int k);
		return (i + GRID_X * (j + GRID_Y * k)) & (DEPTH - 1);
	endfunction

	function automatic longint blend(input longint a, input longint b, input longint t);
		return a * (65536 - t) + b * t;
	endfunction

	function automatic longint round_down(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// Trilinear blend of one component
	function automatic longint trilinear_field(input int comp, input int lx, input longint tx,
		input int ly, input longint ty, input int lz, input longint tz);
		longint c[2][2];
		longint e[2];
		for (int dk = 0; dk < 2; dk++)
			for (int dj = 0; dj < 2; dj++)
				c[dk][dj] = blend(store_m[comp][cell_addr(lx, ly + dj, lz + dk)],
					store_m[comp][cell_addr(lx + 1, ly + dj, lz + dk)], tx);
		for (int dk = 0; dk < 2; dk++)
			e[dk] = round_down(blend(c[dk][0], c[dk][1], ty), 16);
		return round_down(blend(e[0], e[1], tz), 32);
	endfunction

	function automatic field_res_t expected_field(input item_t it);
		field_res_t r;
		int lx, ly, lz;
		longint tx, ty, tz, x, y;
		longint unsigned r2;
		bit ins;
		ins = locate_axis(it.cx, org_m[0], inv_m[0], GRID_X, lx, tx);
		ins = locate_axis(it.cy, org_m[1], inv_m[1], GRID_Y, ly, ty) && ins;
		ins = locate_axis(it.cz, org_m[2], inv_m[2], GRID_Z, lz, tz) && ins;
		if (ins && aper_m != 0) begin
			x = longint'(signed'(it.cx));
			y = longint'(signed'(it.cy));
			r2 = longint'(x * x) + longint'(y * y);
			if (r2 > aper_m) ins = 0;
		end
		r = '{default: '0};
		if (ins) begin
			r.fx = SAMP_W'(trilinear_field(0, lx, tx, ly, ty, lz, tz));
			r.fy = SAMP_W'(trilinear_field(1, lx, tx, ly, ty, lz, tz));
			r.fz = SAMP_W'(trilinear_field(2, lx, tx, ly, ty, lz, tz));
			r.ins = 1'b1;
		end
		return r;
	endfunction

	// Drive one transaction and wait for acceptance, then update the mirror
	task automatic send_item(input item_t it);
		action <= it.act;
		coord_x <= it.cx;
		coord_y <= it.cy;
		coord_z <= it.cz;
		sample_index <= it.idx;
		sample_bx <= it.bx;
		sample_by <= it.by;
		sample_bz <= it.bz;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (it.act == ACT_WRITE) begin
			store_m[0][it.idx] = signed'(it.bx);
			store_m[1][it.idx] = signed'(it.by);
			store_m[2][it.idx] = signed'(it.bz);
			written_m[it.idx] = 1'b1;
			n_write++;
		end else begin
			n_query++;
			if (it.typed) pending_fields.push_back('{default: '0});
			else pending_fields.push_back(expected_field(it));
		end
	endtask

	task automatic maybe_idle();
		if (!quiet && $urandom_range(0, 99) < 17) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_fields.size() != 0 || busy) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_A_W-1:0] a, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		n_cfg++;
		case (a)
			REG_ORIGIN_X: org_m[0] = longint'(signed'(v[31:0]));
			REG_ORIGIN_Y: org_m[1] = longint'(signed'(v[31:0]));
			REG_ORIGIN_Z: org_m[2] = longint'(signed'(v[31:0]));
			REG_INV_X:    inv_m[0] = v[31:0];
			REG_INV_Y:    inv_m[1] = v[31:0];
			REG_INV_Z:    inv_m[2] = v[31:0];
			REG_APER:     aper_m = v;
			default: ;
		endcase
	endtask

	task automatic apply_setting(input setting_t s);
		cfg_write(REG_ORIGIN_X, 63'(unsigned'(s.ox)));
		cfg_write(REG_ORIGIN_Y, 63'(unsigned'(s.oy)));
		cfg_write(REG_ORIGIN_Z, 63'(unsigned'(s.oz)));
		cfg_write(REG_INV_X, 63'(s.ix));
		cfg_write(REG_INV_Y, 63'(s.iy));
		cfg_write(REG_INV_Z, 63'(s.iz));
		cfg_write(REG_APER, s.aper[62:0]);
	endtask

	function automatic item_t mk_query(input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z, input bit typed);
		item_t it;
		it.act = ACT_QUERY;
		it.cx = x;
		it.cy = y;
		it.cz = z;
		it.idx = IDX_W'($urandom);
		it.bx = SAMP_W'($urandom);
		it.by = SAMP_W'($urandom);
		it.bz = SAMP_W'($urandom);
		it.typed = typed;
		return it;
	endfunction

	function automatic item_t mk_write(input int idx, input logic [23:0] bx,
		input logic [23:0] by, input logic [23:0] bz);
		item_t it;
		it = mk_query($urandom, $urandom, $urandom, 0);
		it.act = ACT_WRITE;
		it.idx = IDX_W'(idx);
		it.bx = bx;
		it.by = by;
		it.bz = bz;
		return it;
	endfunction

	// Write any corner of an inside query that was never written
	task automatic fill_corners(input item_t it);
		int lx, ly, lz, a;
		longint tx, ty, tz;
		bit ins;
		ins = locate_axis(it.cx, org_m[0], inv_m[0], GRID_X, lx, tx);
		ins = locate_axis(it.cy, org_m[1], inv_m[1], GRID_Y, ly, ty) && ins;
		ins = locate_axis(it.cz, org_m[2], inv_m[2], GRID_Z, lz, tz) && ins;
		if (ins) begin
			for (int c = 0; c < 8; c++) begin
				a = cell_addr(lx + (c & 1), ly + ((c >> 1) & 1), lz + ((c >> 2) & 1));
				if (!written_m[a]) begin
					send_item(mk_write(a, SAMP_W'($urandom), SAMP_W'($urandom),
						SAMP_W'($urandom)));
					maybe_idle();
				end
			end
		end
	endtask

	function automatic logic [31:0] pick_coord(input longint org, input int unsigned span);
		if ($urandom_range(0, 99) < 80) return 32'(org + longint'($urandom_range(0, span)));
		return $urandom;
	endfunction

	// Result checking
	always @(posedge clk) begin
		field_res_t exp_r;
		if (done) begin
			if (pending_fields.size() == 0) begin
				$display("%0t: result with no transaction waiting: %h %h %h %b", $time,
					field_x, field_y, field_z, inside_res);
				errors++;
			end else begin
				exp_r = pending_fields.pop_front();
				if (inside_res) n_inside++;
				if (field_x !== exp_r.fx || field_y !== exp_r.fy || field_z !== exp_r.fz ||
					inside_res !== exp_r.ins) begin
					$display("%0t: expected %h %h %h %b, actual %h %h %h %b", $time,
						exp_r.fx, exp_r.fy, exp_r.fz, exp_r.ins,
						field_x, field_y, field_z, inside_res);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without an accepted transaction, a result or a config write
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		item_t dir[$];
		item_t it;
		setting_t phases[6];
		org_m = '{0, 0, 0};
		inv_m = '{65536, 65536, 65536};
		aper_m = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under reset settings; outside points have typed zero results
		dir.push_back(mk_write(0, 24'h7FFFFF, 24'h800000, 24'h000000));
		dir.push_back(mk_write(DEPTH - 1, 24'h800000, 24'h7FFFFF, 24'hFFFFFF));
		dir.push_back(mk_write(1, 24'h800000, 24'h800000, 24'h7FFFFF));
		dir.push_back(mk_query(0, 0, 0, 0));
		dir.push_back(mk_query(15 << 16, 15 << 16, 15 << 16, 0));
		dir.push_back(mk_query(15 << 16, 0, 15 << 16, 0));
		dir.push_back(mk_query(32'h8000, 32'h8000, 32'h8000, 0));
		dir.push_back(mk_query(32'hFFFF, 32'hFFFF, 32'hFFFF, 0));
		dir.push_back(mk_query(32'hEFFFF, 32'h7FFFF, 32'h3C000, 0));
		dir.push_back(mk_query((15 << 16) + 1, 0, 0, 1));
		dir.push_back(mk_query(0, (15 << 16) + 1, 0, 1));
		dir.push_back(mk_query(0, 0, (15 << 16) + 1, 1));
		dir.push_back(mk_query(32'hFFFFFFFF, 0, 0, 1));
		dir.push_back(mk_query(0, 32'hFFFFFFFF, 0, 1));
		dir.push_back(mk_query(0, 0, 32'hFFFFFFFF, 1));
		dir.push_back(mk_query(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1));
		dir.push_back(mk_query(32'h80000000, 32'h80000000, 32'h80000000, 1));
		dir.push_back(mk_write(17, 24'h123456, 24'hFEDCBA, 24'h000001));
		dir.push_back(mk_query(32'h18000, 32'h8000, 0, 0));
		foreach (dir[i]) begin
			if (dir[i].act == ACT_QUERY) fill_corners(dir[i]);
			send_item(dir[i]);
			maybe_idle();
		end
		drain();
		cfg_write(REG_UNUSED, '1);

		// Register settings for the random phases, extremes included; spans keep the
		// inside points within the low corner of the grid
		phases[0] = '{0, 0, 0, 65536, 65536, 65536, 64'd10 << 32, (4 << 16) - 1};
		phases[1] = '{-(5 << 16), -(5 << 16), -(5 << 16), 131072, 131072, 131072, 0,
			(2 << 16) - 1};
		phases[2] = '{32'h80000000, 32'h80000000, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, 64'h7FFFFFFFFFFFFFFF, 4};
		phases[3] = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 1, 1, 1, 0};
		phases[4] = '{0, 0, 0, 0, 65536, 32768, 0, (4 << 16) - 1};
		phases[5] = '{$urandom_range(0, 1 << 18) - (1 << 17), $urandom_range(0, 1 << 18) - (1 << 17),
			$urandom_range(0, 1 << 18) - (1 << 17), $urandom_range(1 << 15, 1 << 18),
			$urandom_range(1 << 15, 1 << 18), $urandom_range(1 << 15, 1 << 18),
			{$urandom_range(0, 255), $urandom}, (1 << 16) - 1};

		foreach (phases[p]) begin
			apply_setting(phases[p]);
			for (int n = 0; n < 110; n++) begin
				quiet = (p == 2) || (n >= 40 && n < 90 && p == 0);
				if ($urandom_range(0, 99) < 15) begin
					it = mk_write(cell_addr(int'($urandom_range(0, 4)),
						int'($urandom_range(0, 4)), int'($urandom_range(0, 4))),
						SAMP_W'($urandom), SAMP_W'($urandom), SAMP_W'($urandom));
				end else begin
					it = mk_query(pick_coord(org_m[0], phases[p].span),
						pick_coord(org_m[1], phases[p].span),
						pick_coord(org_m[2], phases[p].span), 0);
					fill_corners(it);
				end
				send_item(it);
				maybe_idle();
			end
			drain();
		end

		$display("Ran %0d queries (%0d inside) and %0d sample writes over %0d register writes.",
			n_query, n_inside, n_write, n_cfg);
		if (errors == 0 && pending_fields.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, pending_fields.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/gfl_pkg.sv
rtl/core/gfl_grid_ram.sv
rtl/core/gfl_locate.sv
rtl/core/gfl_lane.sv
rtl/core/grid_field_trilinear_lookup_unit.sv
dv/grid_field_trilinear_lookup_unit_tb.sv
